// ===== rtl/ssh_pkg.sv =====
// Shared constants and result kind codes for the segment-sphere hit classifier.
package ssh_pkg;

    localparam int COORD_BITS_DEF = 24;   // coordinate width, signed
    localparam int DIR_FRAC       = 28;   // fraction bits of the unit direction

    typedef enum logic [2:0] {
        KIND_COLLISION = 3'd0,
        KIND_INSIDE    = 3'd1,
        KIND_MISSED    = 3'd2,
        KIND_BEHIND    = 3'd3,
        KIND_SHORT     = 3'd4
    } kind_t;

endpackage

// ===== rtl/ssh_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage, with a sideband.
module ssh_sqrt_pipe #(
    parameter int RW  = 64,
    parameter int SBW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RW-1:0]     rad,
    input  logic [SBW-1:0]    side_in,
    output logic              out_valid,
    output logic [RW/2-1:0]   root,
    output logic [SBW-1:0]    side_out
);

    localparam int QW  = RW / 2;
    localparam int RMW = QW + 2;
    localparam int SHW = RMW + 2;

    logic              vld_reg  [1:QW];
    logic [RW-1:0]     x_reg    [1:QW];
    logic [RMW-1:0]    rem_reg  [1:QW];
    logic [QW-1:0]     root_reg [1:QW];
    logic [SBW-1:0]    side_reg [1:QW];

    genvar g;
    generate
        for (g = 0; g < QW; g++)
        begin : g_stage
            logic           v_cur;
            logic [RW-1:0]  x_cur;
            logic [RMW-1:0] rem_cur;
            logic [QW-1:0]  root_cur;
            logic [SBW-1:0] side_cur;
            logic [SHW-1:0] rem_sh;
            logic [SHW-1:0] trial;
            logic           ge;

            if (g == 0)
            begin : g_first
                assign v_cur    = in_valid;
                assign x_cur    = rad;
                assign rem_cur  = '0;
                assign root_cur = '0;
                assign side_cur = side_in;
            end
            else
            begin : g_next
                assign v_cur    = vld_reg[g];
                assign x_cur    = x_reg[g];
                assign rem_cur  = rem_reg[g];
                assign root_cur = root_reg[g];
                assign side_cur = side_reg[g];
            end

            // bring down the next two radicand bits, try root*4+1
            assign rem_sh = {rem_cur, x_cur[RW-1 -: 2]};
            assign trial  = SHW'({root_cur, 2'b01});
            assign ge     = (rem_sh >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g+1] <= 1'b0;
                else if (en)
                    vld_reg[g+1] <= v_cur;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[g+1]    <= x_cur << 2;
                    rem_reg[g+1]  <= RMW'(ge ? rem_sh - trial : rem_sh);
                    root_reg[g+1] <= {root_cur[QW-2:0], ge};
                    side_reg[g+1] <= side_cur;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QW];
    assign root      = root_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

// ===== rtl/ssh_div_pipe.sv =====
// Pipelined restoring divider, several numerators over one divisor, one bit per stage.
// The quotient must fit QW bits, so num >> QW is below den.
module ssh_div_pipe #(
    parameter int NUMW  = 64,
    parameter int DENW  = 32,
    parameter int QW    = 32,
    parameter int LANES = 1,
    parameter int SBW   = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NUMW-1:0]  num,
    input  logic [DENW-1:0]             den,
    input  logic [SBW-1:0]              side_in,
    output logic                        out_valid,
    output logic [LANES-1:0][QW-1:0]    quo,
    output logic [SBW-1:0]              side_out
);

    logic                        vld_reg  [1:QW];
    logic [LANES-1:0][QW-1:0]    lo_reg   [1:QW];
    logic [LANES-1:0][DENW-1:0]  rem_reg  [1:QW];
    logic [LANES-1:0][QW-1:0]    q_reg    [1:QW];
    logic [DENW-1:0]             den_reg  [1:QW];
    logic [SBW-1:0]              side_reg [1:QW];

    genvar g;
    generate
        for (g = 0; g < QW; g++)
        begin : g_stage
            logic                        v_cur;
            logic [LANES-1:0][QW-1:0]    lo_cur;
            logic [LANES-1:0][DENW-1:0]  rem_cur;
            logic [LANES-1:0][QW-1:0]    q_cur;
            logic [DENW-1:0]             den_cur;
            logic [SBW-1:0]              side_cur;
            logic [LANES-1:0][QW-1:0]    lo_next;
            logic [LANES-1:0][DENW-1:0]  rem_next;
            logic [LANES-1:0][QW-1:0]    q_next;

            if (g == 0)
            begin : g_first
                always_comb
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        rem_cur[l] = DENW'(num[l] >> QW);
                        lo_cur[l]  = num[l][QW-1:0];
                    end
                end
                assign v_cur    = in_valid;
                assign q_cur    = '0;
                assign den_cur  = den;
                assign side_cur = side_in;
            end
            else
            begin : g_next
                assign v_cur    = vld_reg[g];
                assign lo_cur   = lo_reg[g];
                assign rem_cur  = rem_reg[g];
                assign q_cur    = q_reg[g];
                assign den_cur  = den_reg[g];
                assign side_cur = side_reg[g];
            end

            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    logic [DENW:0] r2;
                    logic          ge;
                    r2          = {rem_cur[l], lo_cur[l][QW-1]};
                    ge          = (r2 >= {1'b0, den_cur});
                    rem_next[l] = DENW'(ge ? r2 - {1'b0, den_cur} : r2);
                    q_next[l]   = {q_cur[l][QW-2:0], ge};
                    lo_next[l]  = lo_cur[l] << 1;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g+1] <= 1'b0;
                else if (en)
                    vld_reg[g+1] <= v_cur;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    lo_reg[g+1]   <= lo_next;
                    rem_reg[g+1]  <= rem_next;
                    q_reg[g+1]    <= q_next;
                    den_reg[g+1]  <= den_cur;
                    side_reg[g+1] <= side_cur;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QW];
    assign quo       = q_reg[QW];
    assign side_out  = side_reg[QW];

endmodule

// ===== rtl/segment_sphere_hit_classifier_unit.sv =====
// Top level of the segment-sphere hit classifier: stream ports and the main datapath.
//
// Usage: one query word on the s_ side (sphere centre, radius, segment start and end),
// one result word on the m_ side (hit point in m_tdata, kind of hit in m_tuser).
// Kinds: collision, inside (start strictly within the radius), missed, behind, short.
// Hit point is zero for every kind other than collision, and saturated otherwise.
//
// Throughput: one word per cycle in both directions while the receiver keeps m_tready high.
// Pipeline: stages 1 to 3, the segment length root, the unit direction divide, stages V1 to
//   V4, the discriminant root, stages N1 to N3, the offset divide and the output register.
//   The root units yield LW = COORD_BITS+29 (segment length) and SW = COORD_BITS+35
//   (discriminant) bits, one bit per stage, as do the two divider units.
// Stall: the whole pipeline advances only while the output register is empty or taken;
//   s_tready follows that, so a stalled receiver freezes every stage, nothing is lost.
// Reset: clears all stage valid bits; no queries in flight, no clearing pass.
module segment_sphere_hit_classifier_unit #(
    parameter int COORD_BITS = ssh_pkg::COORD_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    // query: center_x, center_y, center_z, sphere_radius (COORD_BITS-1),
    //        start_x, start_y, start_z, end_x, end_y, end_z; zero padded to bytes
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [((10*COORD_BITS-1+7)/8)*8-1:0]        s_tdata,
    // result: hit_x, hit_y, hit_z; zero padded to bytes
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [((3*COORD_BITS+7)/8)*8-1:0]           m_tdata,
    // result: hit_kind
    output ssh_pkg::kind_t                              m_tuser
);

    import ssh_pkg::*;

    localparam int N    = COORD_BITS;
    localparam int DW   = N + 1;                 // differences
    localparam int SQW  = 2 * N + 2;             // sums of three squares
    localparam int LRW  = SQW + 2 * DIR_FRAC;    // length radicand
    localparam int LW   = LRW / 2;               // scaled length
    localparam int UQ   = DIR_FRAC + 2;          // unit direction magnitude
    localparam int UW   = UQ + 1;
    localparam int PW   = DW + UW;
    localparam int VW   = PW + 2;                // projection EO.u
    localparam int HW   = (VW + 1) / 2;
    localparam int HHW  = VW - HW;
    localparam int V2W  = 2 * VW;
    localparam int DRW  = V2W + 2;               // discriminant radicand
    localparam int SW   = DRW / 2;
    localparam int NW   = SW + 2;                // nearer root
    localparam int NLO  = LW / 2;
    localparam int NHI  = LW - NLO;
    localparam int ONW  = DW + LW;               // offset numerator
    localparam int DNW  = DW + 2 * DIR_FRAC;     // direction numerator
    localparam int OUTW = ((3 * N + 7) / 8) * 8;

    localparam logic signed [N+1:0] HMAX = {3'b000, {(N-1){1'b1}}};
    localparam logic signed [N+1:0] HMIN = {3'b111, {(N-1){1'b0}}};

    typedef struct packed {
        logic [2:0][DW-1:0] eo;
        logic [2:0][DW-1:0] dmag;
        logic [2:0]         dneg;
        logic [2:0][N-1:0]  st;
        logic [SQW-1:0]     eo2;
        logic [SQW-1:0]     r2;
        logic               is_inside;
        logic               zero;
    } ctx_a_t;

    typedef struct packed {
        ctx_a_t             a;
        logic [LW-1:0]      ls;
    } ctx_b_t;

    typedef struct packed {
        logic [VW-1:0]      v;
        logic               neg;
        logic [2:0][DW-1:0] dmag;
        logic [2:0]         dneg;
        logic [2:0][N-1:0]  st;
        logic [LW-1:0]      ls;
        logic               is_inside;
        logic               zero;
    } ctx_d_t;

    typedef struct packed {
        kind_t              kind;
        logic [2:0]         dneg;
        logic [2:0][N-1:0]  st;
    } ctx_e_t;

    logic adv;

    // ---------------- stage 1: differences ----------------
    logic               p1_vld_reg;
    logic [2:0][DW-1:0] p1_eo_reg, p1_eo_next;
    logic [2:0][DW-1:0] p1_dmag_reg, p1_dmag_next;
    logic [2:0]         p1_dneg_reg, p1_dneg_next;
    logic [2:0][N-1:0]  p1_st_reg;
    logic [N-2:0]       p1_r_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [N-1:0]  c;
            logic signed [N-1:0]  s;
            logic signed [N-1:0]  e;
            logic signed [DW-1:0] d;
            c = s_tdata[i*N +: N];
            s = s_tdata[4*N-1 + i*N +: N];
            e = s_tdata[7*N-1 + i*N +: N];
            p1_eo_next[i]   = DW'(s) - DW'(c);
            d               = DW'(e) - DW'(s);
            p1_dneg_next[i] = d[DW-1];
            p1_dmag_next[i] = d[DW-1] ? -d : d;
        end
    end

    // ---------------- stage 2: squares ----------------
    logic                 p2_vld_reg;
    logic [2:0][2*DW-1:0] p2_eosq_reg, p2_eosq_next;
    logic [2:0][2*DW-1:0] p2_dsq_reg, p2_dsq_next;
    logic [2*N-3:0]       p2_rsq_reg;
    logic [2:0][DW-1:0]   p2_eo_reg;
    logic [2:0][DW-1:0]   p2_dmag_reg;
    logic [2:0]           p2_dneg_reg;
    logic [2:0][N-1:0]    p2_st_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [DW-1:0] m;
            m = p1_eo_reg[i][DW-1] ? DW'(-p1_eo_reg[i]) : p1_eo_reg[i];
            p2_eosq_next[i] = m * m;
            p2_dsq_next[i]  = p1_dmag_reg[i] * p1_dmag_reg[i];
        end
    end

    // ---------------- stage 3: sums, inside and zero-length tests ----------------
    logic           p3_vld_reg;
    ctx_a_t         p3_ctx_reg, p3_ctx_next;
    logic [SQW-1:0] p3_dd_reg, p3_dd_next;

    always_comb
    begin
        p3_ctx_next.eo   = p2_eo_reg;
        p3_ctx_next.dmag = p2_dmag_reg;
        p3_ctx_next.dneg = p2_dneg_reg;
        p3_ctx_next.st   = p2_st_reg;
        p3_ctx_next.eo2  = SQW'(p2_eosq_reg[0]) + SQW'(p2_eosq_reg[1]) + SQW'(p2_eosq_reg[2]);
        p3_ctx_next.r2   = SQW'(p2_rsq_reg);
        p3_dd_next       = SQW'(p2_dsq_reg[0]) + SQW'(p2_dsq_reg[1]) + SQW'(p2_dsq_reg[2]);
        // a start right on the surface is not inside
        p3_ctx_next.is_inside = (p3_ctx_next.eo2 < p3_ctx_next.r2);
        p3_ctx_next.zero      = (p3_dd_next == '0);
    end

    // ---------------- segment length root ----------------
    logic          sq1_vld;
    logic [LW-1:0] sq1_ls;
    ctx_a_t        sq1_ctx;

    ssh_sqrt_pipe #(
        .RW  (LRW),
        .SBW ($bits(ctx_a_t))
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p3_vld_reg),
        .rad       ({p3_dd_reg, {(2*DIR_FRAC){1'b0}}}),
        .side_in   (p3_ctx_reg),
        .out_valid (sq1_vld),
        .root      (sq1_ls),
        .side_out  (sq1_ctx)
    );

    // ---------------- unit direction divide ----------------
    logic [2:0][DNW-1:0] dv1_num;
    ctx_b_t              dv1_side;
    logic                dv1_vld;
    logic [2:0][UQ-1:0]  dv1_q;
    ctx_b_t              dv1_ctx;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dv1_num[i] = {sq1_ctx.dmag[i], {(2*DIR_FRAC){1'b0}}};
        dv1_side.a  = sq1_ctx;
        dv1_side.ls = sq1_ls;
    end

    ssh_div_pipe #(
        .NUMW  (DNW),
        .DENW  (LW),
        .QW    (UQ),
        .LANES (3),
        .SBW   ($bits(ctx_b_t))
    ) u_dir_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq1_vld),
        .num       (dv1_num),
        .den       (sq1_ls),
        .side_in   (dv1_side),
        .out_valid (dv1_vld),
        .quo       (dv1_q),
        .side_out  (dv1_ctx)
    );

    // ---------------- stage V1: EO_i * u_i ----------------
    logic               p4_vld_reg;
    logic [2:0][PW-1:0] p4_prod_reg, p4_prod_next;
    ctx_b_t             p4_ctx_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [UW-1:0] u;
            logic signed [DW-1:0] eo;
            u  = dv1_ctx.a.dneg[i] ? -$signed({1'b0, dv1_q[i]}) : $signed({1'b0, dv1_q[i]});
            eo = dv1_ctx.a.eo[i];
            p4_prod_next[i] = PW'(eo * u);
        end
    end

    // ---------------- stage V2: projection and magnitude ----------------
    logic          p5_vld_reg;
    logic [VW-1:0] p5_v_reg, p5_v_next;
    logic [VW-1:0] p5_vmag_reg, p5_vmag_next;
    ctx_b_t        p5_ctx_reg;

    always_comb
    begin
        logic signed [VW-1:0] v;
        v = VW'($signed(p4_prod_reg[0])) + VW'($signed(p4_prod_reg[1]))
          + VW'($signed(p4_prod_reg[2]));
        p5_v_next    = v;
        p5_vmag_next = v[VW-1] ? -v : v;
    end

    // ---------------- stage V3: partial products of V^2 ----------------
    logic               p6_vld_reg;
    logic [2*HW-1:0]    p6_pll_reg;
    logic [HW+HHW-1:0]  p6_plh_reg;
    logic [2*HHW-1:0]   p6_phh_reg;
    logic [VW-1:0]      p6_v_reg;
    ctx_b_t             p6_ctx_reg;

    // ---------------- stage V4: discriminant ----------------
    logic           p7_vld_reg;
    logic [DRW-1:0] p7_disc_reg, p7_disc_next;
    ctx_d_t         p7_ctx_reg, p7_ctx_next;

    always_comb
    begin
        logic [V2W-1:0] v2;
        logic [DRW-1:0] a;
        logic [DRW-1:0] b;
        v2 = (V2W'(p6_phh_reg) << (2*HW)) + (V2W'(p6_plh_reg) << (HW+1)) + V2W'(p6_pll_reg);
        a  = DRW'({p6_ctx_reg.a.r2, {(2*DIR_FRAC){1'b0}}}) + DRW'(v2);
        b  = DRW'({p6_ctx_reg.a.eo2, {(2*DIR_FRAC){1'b0}}});
        p7_ctx_next.neg       = (a < b);
        p7_disc_next          = p7_ctx_next.neg ? '0 : a - b;
        p7_ctx_next.v         = p6_v_reg;
        p7_ctx_next.dmag      = p6_ctx_reg.a.dmag;
        p7_ctx_next.dneg      = p6_ctx_reg.a.dneg;
        p7_ctx_next.st        = p6_ctx_reg.a.st;
        p7_ctx_next.ls        = p6_ctx_reg.ls;
        p7_ctx_next.is_inside = p6_ctx_reg.a.is_inside;
        p7_ctx_next.zero      = p6_ctx_reg.a.zero;
    end

    // ---------------- discriminant root ----------------
    logic          sq2_vld;
    logic [SW-1:0] sq2_root;
    ctx_d_t        sq2_ctx;

    ssh_sqrt_pipe #(
        .RW  (DRW),
        .SBW ($bits(ctx_d_t))
    ) u_disc_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p7_vld_reg),
        .rad       (p7_disc_reg),
        .side_in   (p7_ctx_reg),
        .out_valid (sq2_vld),
        .root      (sq2_root),
        .side_out  (sq2_ctx)
    );

    // ---------------- stage N1: nearer root and classification ----------------
    logic               p8_vld_reg;
    ctx_e_t             p8_ctx_reg, p8_ctx_next;
    logic [LW-1:0]      p8_nearm_reg, p8_nearm_next;
    logic [LW-1:0]      p8_ls_reg;
    logic [2:0][DW-1:0] p8_dmag_reg;

    always_comb
    begin
        logic signed [VW-1:0] v;
        logic signed [NW-1:0] near;
        v    = sq2_ctx.v;
        near = -(NW'(v) + $signed({2'b00, sq2_root}));
        priority if (sq2_ctx.is_inside)
            p8_ctx_next.kind = KIND_INSIDE;
        else if (sq2_ctx.zero || sq2_ctx.neg)
            p8_ctx_next.kind = KIND_MISSED;
        else if (near < 0)
            p8_ctx_next.kind = KIND_BEHIND;
        else if (near > $signed(NW'(sq2_ctx.ls)))
            p8_ctx_next.kind = KIND_SHORT;    // a root exactly at the end still hits
        else
            p8_ctx_next.kind = KIND_COLLISION;
        p8_ctx_next.dneg = sq2_ctx.dneg;
        p8_ctx_next.st   = sq2_ctx.st;
        // zero keeps the offset divide in range when there is no hit
        p8_nearm_next = (p8_ctx_next.kind == KIND_COLLISION) ? near[LW-1:0] : '0;
    end

    // ---------------- stage N2: |D_i| * near, split ----------------
    logic                  p9_vld_reg;
    logic [2:0][DW+NLO-1:0] p9_pl_reg, p9_pl_next;
    logic [2:0][DW+NHI-1:0] p9_ph_reg, p9_ph_next;
    logic [LW-1:0]          p9_ls_reg;
    ctx_e_t                 p9_ctx_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p9_pl_next[i] = p8_dmag_reg[i] * p8_nearm_reg[NLO-1:0];
            p9_ph_next[i] = p8_dmag_reg[i] * p8_nearm_reg[LW-1:NLO];
        end
    end

    // ---------------- stage N3: offset numerators ----------------
    logic                p10_vld_reg;
    logic [2:0][ONW-1:0] p10_num_reg, p10_num_next;
    logic [LW-1:0]       p10_ls_reg;
    ctx_e_t              p10_ctx_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            p10_num_next[i] = (ONW'(p9_ph_reg[i]) << NLO) + ONW'(p9_pl_reg[i]);
    end

    // ---------------- offset divide ----------------
    logic               dv2_vld;
    logic [2:0][DW-1:0] dv2_off;
    ctx_e_t             dv2_ctx;

    ssh_div_pipe #(
        .NUMW  (ONW),
        .DENW  (LW),
        .QW    (DW),
        .LANES (3),
        .SBW   ($bits(ctx_e_t))
    ) u_off_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p10_vld_reg),
        .num       (p10_num_reg),
        .den       (p10_ls_reg),
        .side_in   (p10_ctx_reg),
        .out_valid (dv2_vld),
        .quo       (dv2_off),
        .side_out  (dv2_ctx)
    );

    // ---------------- output register: hit point and saturation ----------------
    logic              out_vld_reg;
    kind_t             out_kind_reg;
    logic [2:0][N-1:0] out_hit_reg, out_hit_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [N-1:0] s;
            logic signed [N+1:0] h;
            s = dv2_ctx.st[i];
            if (dv2_ctx.dneg[i])
                h = (N+2)'(s) - $signed({1'b0, dv2_off[i]});
            else
                h = (N+2)'(s) + $signed({1'b0, dv2_off[i]});
            if (dv2_ctx.kind != KIND_COLLISION)
                out_hit_next[i] = '0;
            else if (h > HMAX)
                out_hit_next[i] = HMAX[N-1:0];
            else if (h < HMIN)
                out_hit_next[i] = HMIN[N-1:0];
            else
                out_hit_next[i] = h[N-1:0];
        end
    end

    // ---------------- pipeline control ----------------
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUTW'(out_hit_reg);
    assign m_tuser  = out_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            p4_vld_reg  <= 1'b0;
            p5_vld_reg  <= 1'b0;
            p6_vld_reg  <= 1'b0;
            p7_vld_reg  <= 1'b0;
            p8_vld_reg  <= 1'b0;
            p9_vld_reg  <= 1'b0;
            p10_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_vld_reg  <= s_tvalid;
            p2_vld_reg  <= p1_vld_reg;
            p3_vld_reg  <= p2_vld_reg;
            p4_vld_reg  <= dv1_vld;
            p5_vld_reg  <= p4_vld_reg;
            p6_vld_reg  <= p5_vld_reg;
            p7_vld_reg  <= p6_vld_reg;
            p8_vld_reg  <= sq2_vld;
            p9_vld_reg  <= p8_vld_reg;
            p10_vld_reg <= p9_vld_reg;
            out_vld_reg <= dv2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_eo_reg    <= p1_eo_next;
            p1_dmag_reg  <= p1_dmag_next;
            p1_dneg_reg  <= p1_dneg_next;
            for (int i = 0; i < 3; i++)
                p1_st_reg[i] <= s_tdata[4*N-1 + i*N +: N];
            p1_r_reg     <= s_tdata[3*N +: N-1];

            p2_eosq_reg  <= p2_eosq_next;
            p2_dsq_reg   <= p2_dsq_next;
            p2_rsq_reg   <= p1_r_reg * p1_r_reg;
            p2_eo_reg    <= p1_eo_reg;
            p2_dmag_reg  <= p1_dmag_reg;
            p2_dneg_reg  <= p1_dneg_reg;
            p2_st_reg    <= p1_st_reg;

            p3_ctx_reg   <= p3_ctx_next;
            p3_dd_reg    <= p3_dd_next;

            p4_prod_reg  <= p4_prod_next;
            p4_ctx_reg   <= dv1_ctx;

            p5_v_reg     <= p5_v_next;
            p5_vmag_reg  <= p5_vmag_next;
            p5_ctx_reg   <= p4_ctx_reg;

            p6_pll_reg   <= p5_vmag_reg[HW-1:0] * p5_vmag_reg[HW-1:0];
            p6_plh_reg   <= p5_vmag_reg[HW-1:0] * p5_vmag_reg[VW-1:HW];
            p6_phh_reg   <= p5_vmag_reg[VW-1:HW] * p5_vmag_reg[VW-1:HW];
            p6_v_reg     <= p5_v_reg;
            p6_ctx_reg   <= p5_ctx_reg;

            p7_disc_reg  <= p7_disc_next;
            p7_ctx_reg   <= p7_ctx_next;

            p8_ctx_reg   <= p8_ctx_next;
            p8_nearm_reg <= p8_nearm_next;
            p8_ls_reg    <= sq2_ctx.ls;
            p8_dmag_reg  <= sq2_ctx.dmag;

            p9_pl_reg    <= p9_pl_next;
            p9_ph_reg    <= p9_ph_next;
            p9_ls_reg    <= p8_ls_reg;
            p9_ctx_reg   <= p8_ctx_reg;

            p10_num_reg  <= p10_num_next;
            p10_ls_reg   <= p9_ls_reg;
            p10_ctx_reg  <= p9_ctx_reg;

            out_kind_reg <= dv2_ctx.kind;
            out_hit_reg  <= out_hit_next;
        end
    end

    // ---------------- assertions ----------------
    a_no_hit_point: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != KIND_COLLISION) |-> (m_tdata == '0))
        else $error("hit point not zero on a non-collision word");

    a_near_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (p8_vld_reg && p8_ctx_reg.kind == KIND_COLLISION) |-> (p8_nearm_reg <= p8_ls_reg))
        else $error("collision root beyond segment length");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_vld_reg && !adv) |=> (p1_vld_reg && $stable(p1_eo_reg)))
        else $error("first stage lost its word during a stall");

endmodule
